>>> sv/stq_pkg.sv
// ---------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue: entry layout,
// action and status codes, controller states and the per-cell command.
// ---------------------------------------------------------------------------
package stq_pkg;

  // default number of timer slots
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned PL_W     = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HELD_W   = 5;

  // first id handed out after reset
  localparam logic [ID_W-1:0] FIRST_ID = ID_W'(1);

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_CANCEL  = 3'd1,
    ACT_RESET   = 3'd2,
    ACT_EXECUTE = 3'd3,
    ACT_POLL    = 3'd4
  } action_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_PLACE,
    S_DONE
  } state_t;

  // what every cell does in a given cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_PLACE
  } cell_mode_t;

  // one stored timer
  typedef struct packed {
    logic [TIME_W-1:0] dl;
    logic [ID_W-1:0]   id;
    logic [PL_W-1:0]   pl;
  } entry_t;

  // command broadcast to the whole row of cells
  typedef struct packed {
    cell_mode_t        mode;
    logic              by_id;
    logic              by_due;
    logic [TIME_W-1:0] key_dl;
    logic [ID_W-1:0]   key_id;
    logic [PL_W-1:0]   key_pl;
  } cell_cmd_t;

endpackage

>>> sv/sorted_timer_queue.sv
// ---------------------------------------------------------------------------
// sorted_timer_queue
// Bounded timer table kept in ascending deadline order in a row of cells.
// ---------------------------------------------------------------------------
// Usage: one command beat enters on the input channel (in_valid/in_stall)
// carrying action, now_ms, delay_ms, timer_id and payload. Exactly one
// result beat leaves on the output channel (out_valid/out_stall) with
// status, result_id, fired, fired_payload and entries_held.
// Cancel, execute, poll, an insert into a full table and every miss go
// from accept through the removal step and the done step to the result
// register; insert and reset add a place step after the removal step, in
// which the row of cells opens a slot. The next command is taken in the
// cycle after the result is registered, so no command is taken before the
// last one is through. Each step is a single pass of the row: every cell
// compares its own entry to the broadcast key and moves data one place.
// A finished result sits in the output register while the next command is
// taken; a stalled output holds its beat, and a command whose result is
// ready waits in its final step until the output register frees up.
// Reset empties the table and restarts ids at 1; slot contents are not
// cleared, an occupancy count marks which slots hold timers.
// ---------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stq_pkg::ACTION_W-1:0]  action,
  input  logic [stq_pkg::TIME_W-1:0]    now_ms,
  input  logic [stq_pkg::TIME_W-1:0]    delay_ms,
  input  logic [stq_pkg::ID_W-1:0]      timer_id,
  input  logic [stq_pkg::PL_W-1:0]      payload,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stq_pkg::STATUS_W-1:0]  status,
  output logic [stq_pkg::ID_W-1:0]      result_id,
  output logic                          fired,
  output logic [stq_pkg::PL_W-1:0]      fired_payload,
  output logic [stq_pkg::HELD_W-1:0]    entries_held
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  stq_pkg::state_t   state, state_next;
  stq_pkg::cell_cmd_t cmd;

  // command registers
  logic [stq_pkg::ACTION_W-1:0] cmd_action;
  logic [stq_pkg::TIME_W-1:0]   cmd_now;
  logic [stq_pkg::TIME_W-1:0]   cmd_dl;
  logic [stq_pkg::ID_W-1:0]     cmd_id;
  logic [stq_pkg::PL_W-1:0]     cmd_pl;
  logic [stq_pkg::ID_W-1:0]     place_id;
  logic [stq_pkg::PL_W-1:0]     place_pl;

  // working result
  stq_pkg::status_t             res_status;
  logic [stq_pkg::ID_W-1:0]     res_id;
  logic                         res_fired;
  logic [stq_pkg::PL_W-1:0]     res_pl;

  // table state
  logic [CW-1:0]                count;
  logic [stq_pkg::ID_W-1:0]     next_ident;

  // row wiring
  stq_pkg::entry_t              entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]       occ;
  logic [QUEUE_DEPTH-1:0]       le_v;
  logic [QUEUE_DEPTH-1:0]       hit_v;
  logic [QUEUE_DEPTH:0]         seen_v;
  stq_pkg::entry_t              gathered;

  logic accept;
  logic out_free;
  logic hit_any;
  logic is_full;
  logic by_id_act;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign hit_any  = seen_v[QUEUE_DEPTH];
  assign is_full  = (count == CW'(QUEUE_DEPTH));
  assign by_id_act = (cmd_action == stq_pkg::ACT_CANCEL) ||
                     (cmd_action == stq_pkg::ACT_RESET) ||
                     (cmd_action == stq_pkg::ACT_EXECUTE);

  // row of cells, head at index 0
  assign seen_v[0] = 1'b0;
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    assign occ[k] = (CW'(k) < count);
    stq_cell u_cell (
      .clk        (clk),
      .occ        (occ[k]),
      .head       ((k == 0) ? 1'b1 : 1'b0),
      .cmd        (cmd),
      .prev_entry ((k == 0) ? entries[0] : entries[(k == 0) ? 0 : k - 1]),
      .prev_le    ((k == 0) ? 1'b1 : le_v[(k == 0) ? 0 : k - 1]),
      .seen_in    (seen_v[k]),
      .next_entry ((k == QUEUE_DEPTH - 1) ? entries[k]
                                          : entries[(k == QUEUE_DEPTH - 1) ? k : k + 1]),
      .entry      (entries[k]),
      .le         (le_v[k]),
      .seen_out   (seen_v[k+1]),
      .hit        (hit_v[k])
    );
  end

  // pick out the first matching entry
  always_comb begin
    gathered = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gathered = stq_pkg::entry_t'(gathered | (hit_v[i] ? entries[i] : '0));
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and row command
  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    cmd.mode    = stq_pkg::CELL_HOLD;
    cmd.by_id   = 1'b0;
    cmd.by_due  = 1'b0;
    cmd.key_dl  = cmd_now;
    cmd.key_id  = cmd_id;
    cmd.key_pl  = cmd_pl;
    case (state)
      stq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = stq_pkg::S_REMOVE;
        end
      end
      stq_pkg::S_REMOVE: begin
        cmd.mode   = stq_pkg::CELL_REMOVE;
        cmd.by_id  = by_id_act && (cmd_id != '0);
        cmd.by_due = (cmd_action == stq_pkg::ACT_POLL);
        if (((cmd_action == stq_pkg::ACT_INSERT) && !is_full) ||
            ((cmd_action == stq_pkg::ACT_RESET) && hit_any)) begin
          state_next = stq_pkg::S_PLACE;
        end else begin
          state_next = stq_pkg::S_DONE;
        end
      end
      stq_pkg::S_PLACE: begin
        cmd.mode   = stq_pkg::CELL_PLACE;
        cmd.key_dl = cmd_dl;
        cmd.key_id = place_id;
        cmd.key_pl = place_pl;
        state_next = stq_pkg::S_DONE;
      end
      stq_pkg::S_DONE: begin
        if (out_free) begin
          state_next = stq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stq_pkg::S_IDLE;
      end
    endcase
  end

  // command capture and working result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_action <= action;
      cmd_now    <= now_ms;
      cmd_dl     <= now_ms + delay_ms;
      cmd_id     <= timer_id;
      cmd_pl     <= payload;
      res_status <= stq_pkg::ST_MISS;
      res_id     <= '0;
      res_fired  <= 1'b0;
      res_pl     <= '0;
    end else if (state == stq_pkg::S_REMOVE) begin
      case (cmd_action)
        stq_pkg::ACT_INSERT: begin
          place_id <= next_ident;
          place_pl <= cmd_pl;
          if (is_full) begin
            res_status <= stq_pkg::ST_FULL;
          end else begin
            res_status <= stq_pkg::ST_OK;
            res_id     <= next_ident;
          end
        end
        stq_pkg::ACT_CANCEL: begin
          if (hit_any) begin
            res_status <= stq_pkg::ST_OK;
          end
        end
        stq_pkg::ACT_RESET: begin
          place_id <= gathered.id;
          place_pl <= gathered.pl;
          if (hit_any) begin
            res_status <= stq_pkg::ST_OK;
          end
        end
        stq_pkg::ACT_EXECUTE, stq_pkg::ACT_POLL: begin
          if (hit_any) begin
            res_status <= stq_pkg::ST_OK;
            res_id     <= gathered.id;
            res_fired  <= 1'b1;
            res_pl     <= gathered.pl;
          end
        end
        default: begin
          res_status <= stq_pkg::ST_MISS;
        end
      endcase
    end
  end

  // occupancy count and id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      next_ident <= stq_pkg::FIRST_ID;
    end else if ((state == stq_pkg::S_REMOVE) && hit_any) begin
      count <= count - CW'(1);
    end else if (state == stq_pkg::S_PLACE) begin
      count <= count + CW'(1);
      if (cmd_action == stq_pkg::ACT_INSERT) begin
        next_ident <= (next_ident == '1) ? stq_pkg::FIRST_ID : next_ident + stq_pkg::ID_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == stq_pkg::S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if ((state == stq_pkg::S_DONE) && out_free) begin
      status        <= res_status;
      result_id     <= res_id;
      fired         <= res_fired;
      fired_payload <= res_pl;
      entries_held  <= stq_pkg::HELD_W'(count);
    end
  end

endmodule

>>> sv/stq_cell.sv
// ---------------------------------------------------------------------------
// stq_cell
// One slot of the sorted timer row. Holds one entry, flags a match for
// removal, and on remove or place takes a neighbor's entry or the new one.
// ---------------------------------------------------------------------------
module stq_cell (
  input  logic                  clk,
  input  logic                  occ,
  input  logic                  head,
  input  stq_pkg::cell_cmd_t    cmd,
  input  stq_pkg::entry_t       prev_entry,
  input  logic                  prev_le,
  input  logic                  seen_in,
  input  stq_pkg::entry_t       next_entry,
  output stq_pkg::entry_t       entry,
  output logic                  le,
  output logic                  seen_out,
  output logic                  hit
);

  stq_pkg::entry_t entry_next;
  stq_pkg::entry_t new_entry;
  logic            match;

  // match for removal and ordering flag against the broadcast deadline
  always_comb begin
    match = occ && ((cmd.by_id && (entry.id == cmd.key_id)) ||
                    (cmd.by_due && head && (entry.dl < cmd.key_dl)));
    seen_out = seen_in | match;
    hit      = match & ~seen_in;
    le       = occ && (entry.dl <= cmd.key_dl);
  end

  // next content: shift toward head on remove, open a gap and write the new entry on place
  always_comb begin
    new_entry.dl = cmd.key_dl;
    new_entry.id = cmd.key_id;
    new_entry.pl = cmd.key_pl;
    entry_next   = entry;
    case (cmd.mode)
      stq_pkg::CELL_REMOVE: begin
        if (seen_out) begin
          entry_next = next_entry;
        end
      end
      stq_pkg::CELL_PLACE: begin
        if (!le) begin
          entry_next = prev_le ? new_entry : prev_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

>>> sv/stq_checker.sv
// ---------------------------------------------------------------------------
// stq_checker
// Port-level checks for the sorted timer queue, bound to the top level.
// ---------------------------------------------------------------------------
module stq_checker #(
  parameter int unsigned QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [stq_pkg::STATUS_W-1:0] status,
  input logic [stq_pkg::ID_W-1:0]     result_id,
  input logic                         fired,
  input logic [stq_pkg::PL_W-1:0]     fired_payload,
  input logic [stq_pkg::HELD_W-1:0]   entries_held
);

  localparam logic [stq_pkg::HELD_W-1:0] HELD_MAX = stq_pkg::HELD_W'(QUEUE_DEPTH);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown after reset");

  // a fired beat always reports success with a real id
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fired) |-> (status == stq_pkg::ST_OK && result_id != '0))
    else $error("fired beat without ok status or id");

  // no payload leaks out of a beat that did not fire
  a_quiet_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fired) |-> (fired_payload == '0))
    else $error("payload shown on a beat that did not fire");

  // full status only with a full table and no id
  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == stq_pkg::ST_FULL) |->
      (result_id == '0 && entries_held == HELD_MAX))
    else $error("full status with wrong id or count");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_id) && $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind sorted_timer_queue stq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_stq_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .result_id     (result_id),
  .fired         (fired),
  .fired_payload (fired_payload),
  .entries_held  (entries_held)
);
